### rtl/tlf_pkg.sv
// ----------------------------------------------------------------------------
// Track layout formatter package
// Shared constants, payload types and the fixed run table.
// ----------------------------------------------------------------------------
package tlf_pkg;

   localparam int SECTOR_BYTES    = 512;
   localparam int MAX_SECTORS     = 32;
   localparam int MAX_TRACK_BYTES = 32768;
   localparam int MIN_TRACK_BYTES = 6250;

   localparam int BIS_W  = $clog2(SECTOR_BYTES);
   localparam int IDX_W  = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int NSEC_W = 7;
   localparam int CSR_ADDR_W = 3;

   localparam logic [7:0] GAP_BYTE   = 8'h4E;
   localparam logic [7:0] SYNC_BYTE  = 8'h00;
   localparam logic [7:0] IAM_BYTE   = 8'hC2;
   localparam logic [7:0] IAM_MARK   = 8'hFC;
   localparam logic [7:0] ADDR_BYTE  = 8'hA1;
   localparam logic [7:0] IDAM_MARK  = 8'hFE;
   localparam logic [7:0] DAM_MARK   = 8'hFB;
   localparam logic [7:0] FILL_BYTE  = 8'hE5;
   localparam logic [7:0] SIZE_CODE  = 8'h02;

   localparam logic [6:0] GAP3_SHORT  = 7'd84;
   localparam logic [6:0] GAP3_MEDIUM = 7'd54;
   localparam logic [6:0] GAP3_LONG   = 7'd38;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   localparam logic REG_SECTORS     = 1'b0;
   localparam logic REG_TRACK_BYTES = 1'b1;

   localparam logic [5:0]  SECTORS_RESET     = 6'd18;
   localparam logic [15:0] TRACK_BYTES_RESET = 16'd20736;

   // run identifiers, issued in increasing order
   localparam logic [4:0] ID_PRE0  = 5'd0;
   localparam logic [4:0] ID_PRE1  = 5'd1;
   localparam logic [4:0] ID_PRE2  = 5'd2;
   localparam logic [4:0] ID_PRE3  = 5'd3;
   localparam logic [4:0] ID_PRE4  = 5'd4;
   localparam logic [4:0] ID_HDR0  = 5'd5;
   localparam logic [4:0] ID_HDR1  = 5'd6;
   localparam logic [4:0] ID_HDR2  = 5'd7;
   localparam logic [4:0] ID_CYL   = 5'd8;
   localparam logic [4:0] ID_HEAD  = 5'd9;
   localparam logic [4:0] ID_REC   = 5'd10;
   localparam logic [4:0] ID_SIZE  = 5'd11;
   localparam logic [4:0] ID_HCRC  = 5'd12;
   localparam logic [4:0] ID_GAP2  = 5'd13;
   localparam logic [4:0] ID_DSYNC = 5'd14;
   localparam logic [4:0] ID_DADR  = 5'd15;
   localparam logic [4:0] ID_DAM   = 5'd16;
   localparam logic [4:0] ID_DATA  = 5'd17;
   localparam logic [4:0] ID_DCRC  = 5'd18;
   localparam logic [4:0] ID_GAP3  = 5'd19;
   localparam logic [4:0] ID_TAIL  = 5'd20;

   typedef struct packed {
      logic       req_type;
      logic [7:0] cylinder;
      logic       head;
      logic [7:0] data_value;
      logic       data_absent;
   } req_data_type;

   typedef struct packed {
      logic [7:0]  run_value;
      logic [15:0] run_count;
      logic        last;
   } rsp_data_type;

   typedef struct packed {
      logic [5:0]  sectors_per_track;
      logic [15:0] track_bytes;
   } cfg_type;

   function automatic rsp_data_type fixed_run(logic [4:0] id);
      rsp_data_type r;
      r.last = 1'b0;
      case (id)
         ID_PRE0:  begin r.run_value = GAP_BYTE;  r.run_count = 16'd80; end
         ID_PRE1:  begin r.run_value = SYNC_BYTE; r.run_count = 16'd12; end
         ID_PRE2:  begin r.run_value = IAM_BYTE;  r.run_count = 16'd3;  end
         ID_PRE3:  begin r.run_value = IAM_MARK;  r.run_count = 16'd1;  end
         ID_PRE4:  begin r.run_value = GAP_BYTE;  r.run_count = 16'd50; end
         ID_HDR0:  begin r.run_value = SYNC_BYTE; r.run_count = 16'd12; end
         ID_HDR1:  begin r.run_value = ADDR_BYTE; r.run_count = 16'd3;  end
         ID_HDR2:  begin r.run_value = IDAM_MARK; r.run_count = 16'd1;  end
         ID_SIZE:  begin r.run_value = SIZE_CODE; r.run_count = 16'd1;  end
         ID_HCRC:  begin r.run_value = SYNC_BYTE; r.run_count = 16'd2;  end
         ID_GAP2:  begin r.run_value = GAP_BYTE;  r.run_count = 16'd22; end
         ID_DSYNC: begin r.run_value = SYNC_BYTE; r.run_count = 16'd12; end
         ID_DADR:  begin r.run_value = ADDR_BYTE; r.run_count = 16'd3;  end
         ID_DAM:   begin r.run_value = DAM_MARK;  r.run_count = 16'd1;  end
         ID_DCRC:  begin r.run_value = SYNC_BYTE; r.run_count = 16'd2;  end
         ID_GAP3:  begin r.run_value = GAP_BYTE;  r.run_count = 16'd0;  end
         ID_TAIL:  begin r.run_value = GAP_BYTE;  r.run_count = 16'd0;  end
         default:  begin r.run_value = SYNC_BYTE; r.run_count = 16'd1;  end
      endcase
      return r;
   endfunction

endpackage

### rtl/tlf_csr.sv
// ----------------------------------------------------------------------------
// Track layout formatter register file
// APB-style register port for sector count and track length.
// ----------------------------------------------------------------------------
module tlf_csr
   import tlf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [5:0]  sectors_ff;
   logic [5:0]  sectors_in;
   logic [15:0] track_ff;
   logic [15:0] track_in;
   logic        wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      sectors_in = sectors_ff;
      track_in   = track_ff;
      if (wr) begin
         case (csr_paddr[2])
            REG_SECTORS:     sectors_in = csr_pwdata[5:0];
            REG_TRACK_BYTES: track_in   = csr_pwdata[15:0];
            default:         sectors_in = sectors_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sectors_ff <= SECTORS_RESET;
         track_ff   <= TRACK_BYTES_RESET;
      end else begin
         sectors_ff <= sectors_in;
         track_ff   <= track_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SECTORS:     csr_prdata = {26'd0, sectors_ff};
         REG_TRACK_BYTES: csr_prdata = {16'd0, track_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready            = 1'b1;
   assign cfg.sectors_per_track = sectors_ff;
   assign cfg.track_bytes       = track_ff;

endmodule

### rtl/tlf_seq.sv
// ----------------------------------------------------------------------------
// Track layout formatter run sequencer
// Latches one item, updates track state and issues its runs one per cycle while out_ready.
// ----------------------------------------------------------------------------
module tlf_seq
   import tlf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   input  logic         out_ready,
   output logic         run_valid,
   output rsp_data_type run_data
);

   logic             busy_ff, busy_in;
   logic             active_ff, active_in;
   logic [4:0]       cur_id_ff, cur_id_in;
   logic [4:0]       end_id_ff, end_id_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [BIS_W-1:0] bis_ff, bis_in;
   logic [15:0]      pos_ff, pos_in;
   logic [7:0]       cyl_ff, cyl_in;
   logic             head_ff, head_in;
   logic [7:0]       byte_ff, byte_in;
   logic [6:0]       gap3_ff, gap3_in;

   logic              issue;
   logic              done;
   logic              accept;
   logic [NSEC_W-1:0] nsec;
   logic [NSEC_W-1:0] idx_next;
   logic [15:0]       eff_len;
   logic [16:0]       pos_sum;
   logic              eos;
   logic [6:0]        gap3_sel;

   assign issue     = busy_ff && out_ready;
   assign done      = issue && (cur_id_ff == end_id_ff);
   assign req_stall = busy_ff && !done;
   assign accept    = req_valid && !req_stall;
   assign run_valid = issue;

   always_comb begin
      if (cfg.sectors_per_track == 6'd0) begin
         nsec = NSEC_W'(1);
      end else if ({1'b0, cfg.sectors_per_track} > NSEC_W'(MAX_SECTORS)) begin
         nsec = NSEC_W'(MAX_SECTORS);
      end else begin
         nsec = {1'b0, cfg.sectors_per_track};
      end
   end

   always_comb begin
      if (cfg.track_bytes < 16'(MIN_TRACK_BYTES)) begin
         eff_len = 16'(MIN_TRACK_BYTES);
      end else if (cfg.track_bytes > 16'(MAX_TRACK_BYTES)) begin
         eff_len = 16'(MAX_TRACK_BYTES);
      end else begin
         eff_len = cfg.track_bytes;
      end
   end

   always_comb begin
      if (nsec inside {[0:9]}) begin
         gap3_sel = GAP3_SHORT;
      end else if (nsec inside {[10:15]}) begin
         gap3_sel = GAP3_MEDIUM;
      end else begin
         gap3_sel = GAP3_LONG;
      end
   end

   assign idx_next = NSEC_W'(idx_ff) + NSEC_W'(1);
   assign eos      = (bis_ff == BIS_W'(SECTOR_BYTES - 1));

   always_comb begin
      run_data = fixed_run(cur_id_ff);
      case (cur_id_ff)
         ID_CYL:  run_data.run_value = cyl_ff;
         ID_HEAD: run_data.run_value = {7'd0, head_ff};
         ID_REC:  run_data.run_value = 8'(idx_next);
         ID_DATA: run_data.run_value = byte_ff;
         ID_GAP3: run_data.run_count = {9'd0, gap3_ff};
         ID_TAIL: begin
            run_data.run_count = (pos_ff < eff_len) ? (eff_len - pos_ff) : 16'd0;
            run_data.last      = 1'b1;
         end
         default: run_data.last = 1'b0;
      endcase
   end

   assign pos_sum = {1'b0, pos_ff} + {1'b0, run_data.run_count};

   always_comb begin
      busy_in   = busy_ff;
      active_in = active_ff;
      cur_id_in = cur_id_ff;
      end_id_in = end_id_ff;
      idx_in    = idx_ff;
      bis_in    = bis_ff;
      cyl_in    = cyl_ff;
      head_in   = head_ff;
      byte_in   = byte_ff;
      gap3_in   = gap3_ff;
      pos_in    = pos_ff;

      if (issue) begin
         pos_in = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
         if (done) begin
            busy_in = 1'b0;
         end else begin
            cur_id_in = cur_id_ff + 5'd1;
         end
      end

      if (accept) begin
         if (req_data.req_type == REQ_START) begin
            cyl_in    = req_data.cylinder;
            head_in   = req_data.head;
            pos_in    = 16'd0;
            idx_in    = '0;
            bis_in    = '0;
            active_in = 1'b1;
            busy_in   = 1'b1;
            cur_id_in = ID_PRE0;
            end_id_in = ID_PRE4;
         end else if (active_ff) begin
            busy_in   = 1'b1;
            cur_id_in = (bis_ff == '0) ? ID_HDR0 : ID_DATA;
            byte_in   = req_data.data_absent ? FILL_BYTE : req_data.data_value;
            if (eos) begin
               bis_in  = '0;
               gap3_in = gap3_sel;
               if (idx_next >= nsec) begin
                  end_id_in = ID_TAIL;
                  active_in = 1'b0;
                  idx_in    = '0;
               end else begin
                  end_id_in = ID_GAP3;
                  idx_in    = IDX_W'(idx_next);
               end
            end else begin
               bis_in    = bis_ff + BIS_W'(1);
               end_id_in = ID_DATA;
            end
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         active_ff <= 1'b0;
         cur_id_ff <= ID_PRE0;
         end_id_ff <= ID_PRE0;
         idx_ff    <= '0;
         bis_ff    <= '0;
         pos_ff    <= 16'd0;
         cyl_ff    <= 8'd0;
         head_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         active_ff <= active_in;
         cur_id_ff <= cur_id_in;
         end_id_ff <= end_id_in;
         idx_ff    <= idx_in;
         bis_ff    <= bis_in;
         pos_ff    <= pos_in;
         cyl_ff    <= cyl_in;
         head_ff   <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      gap3_ff <= gap3_in;
   end

`ifndef SYNTH
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_id_ff <= end_id_ff))
      else $error("run id past end of item");

   a_idle_data: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == REQ_DATA && !active_ff) |=> !busy_ff)
      else $error("data without open track produced runs");

   a_tail_closes: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cur_id_ff == ID_TAIL) |-> (!active_ff && idx_ff == '0))
      else $error("tail run while track still open");

   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.req_type == REQ_START) |=>
         (pos_ff == 16'd0 && cur_id_ff == ID_PRE0 && busy_ff))
      else $error("start did not reset track position");
`endif

endmodule

### rtl/tlf_out_reg.sv
// ----------------------------------------------------------------------------
// Track layout formatter output register
// Holds one run for the result channel and frees itself on a transfer.
// ----------------------------------------------------------------------------
module tlf_out_reg
   import tlf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         run_valid,
   input  rsp_data_type run_data,
   output logic         out_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   logic         valid_ff, valid_in;
   rsp_data_type data_ff, data_in;

   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = run_valid || (valid_ff && rsp_stall);
   assign data_in   = (run_valid && out_ready) ? run_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### rtl/ibm_track_layout_formatter.sv
// ----------------------------------------------------------------------------
// IBM track layout formatter
// Turns start and data items into the run list of one track image.
// ----------------------------------------------------------------------------
// Path: an accepted item sits in the sequencer state; each of its runs is then
// registered in the output register before it shows on rsp. Throughput: one run
// per cycle while the output register takes it; an item has 1 run per data byte,
// 13 with a sector header, 3 or 4 at a sector end, 5 for a start, 0 if ignored.
// Reset: synchronous; 18 sectors, 20736 track bytes, no track open.
module ibm_track_layout_formatter
   import tlf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg;
   logic         out_ready;
   logic         run_valid;
   rsp_data_type run_data;

   tlf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tlf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_ready (out_ready),
      .run_valid (run_valid),
      .run_data  (run_data)
   );

   tlf_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .run_valid (run_valid),
      .run_data  (run_data),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Track layout formatter testbench
// Drives start and data items into the formatter and checks every run it
// emits against an in-bench model of the track layout. A short table of
// directed items comes first, followed by random noise and then short tracks
// under out-of-range sector counts and track lengths. Both channels idle
// at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
   import tlf_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int CLK_PERIOD   = 2 * HALF_PERIOD;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int IDLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES = 20;
   localparam int PRESSURE_AT  = 100;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_RUN, ROW_ONE_BYTE, ROW_PREAMBLE} row_form_type;

   typedef struct packed {
      req_data_type rq;
      row_form_type form;
      logic [7:0]   byte_exp;
   } stim_row_type;

   // fields: {req_type, cylinder, head, data_value, data_absent}, form, typed byte
   localparam int DIR_ROWS = 17;
   localparam stim_row_type DIR_TABLE [DIR_ROWS] = '{
      '{'{REQ_DATA,  8'hFF, 1'b1, 8'hFF, 1'b1}, ROW_NO_RUN,   8'h00},
      '{'{REQ_DATA,  8'h00, 1'b0, 8'h00, 1'b0}, ROW_NO_RUN,   8'h00},
      '{'{REQ_START, 8'h00, 1'b0, 8'h00, 1'b0}, ROW_PREAMBLE, 8'h00},
      '{'{REQ_DATA,  8'h00, 1'b0, 8'h00, 1'b0}, ROW_PREDICT,  8'h00},
      '{'{REQ_DATA,  8'hFF, 1'b1, 8'hFF, 1'b0}, ROW_ONE_BYTE, 8'hFF},
      '{'{REQ_DATA,  8'h00, 1'b0, 8'h00, 1'b1}, ROW_ONE_BYTE, FILL_BYTE},
      '{'{REQ_DATA,  8'hFF, 1'b1, 8'hFF, 1'b1}, ROW_ONE_BYTE, FILL_BYTE},
      '{'{REQ_DATA,  8'h12, 1'b0, 8'h80, 1'b0}, ROW_ONE_BYTE, 8'h80},
      '{'{REQ_DATA,  8'h34, 1'b1, 8'h01, 1'b0}, ROW_ONE_BYTE, 8'h01},
      '{'{REQ_START, 8'hFF, 1'b1, 8'hFF, 1'b1}, ROW_PREAMBLE, 8'h00},
      '{'{REQ_DATA,  8'h00, 1'b0, 8'h5A, 1'b0}, ROW_PREDICT,  8'h00},
      '{'{REQ_DATA,  8'h00, 1'b0, 8'hA5, 1'b0}, ROW_ONE_BYTE, 8'hA5},
      '{'{REQ_DATA,  8'hFF, 1'b1, 8'h7F, 1'b0}, ROW_ONE_BYTE, 8'h7F},
      '{'{REQ_START, 8'h55, 1'b0, 8'h00, 1'b0}, ROW_PREAMBLE, 8'h00},
      '{'{REQ_START, 8'hAA, 1'b1, 8'h00, 1'b1}, ROW_PREAMBLE, 8'h00},
      '{'{REQ_DATA,  8'h0F, 1'b0, 8'h3C, 1'b0}, ROW_PREDICT,  8'h00},
      '{'{REQ_DATA,  8'hF0, 1'b1, 8'hC3, 1'b1}, ROW_ONE_BYTE, FILL_BYTE}
   };

   localparam rsp_data_type PREAMBLE_RUNS [5] = '{
      '{GAP_BYTE,  16'd80, 1'b0},
      '{SYNC_BYTE, 16'd12, 1'b0},
      '{IAM_BYTE,  16'd3,  1'b0},
      '{IAM_MARK,  16'd1,  1'b0},
      '{GAP_BYTE,  16'd50, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_data_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   rsp_data_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // layout model state
   logic [5:0]   sectors_cfg = SECTORS_RESET;
   logic [15:0]  trk_bytes_cfg = TRACK_BYTES_RESET;
   logic [15:0]  trk_pos = '0;
   int           sec_idx = 0;
   int           byte_idx = 0;
   logic [7:0]   cur_cyl = '0;
   logic         cur_head = 1'b0;
   logic         track_open = 1'b0;

   rsp_data_type new_runs [$];
   rsp_data_type expected_runs [$];
   int           err_count = 0;
   int           runs_seen = 0;
   logic         send_calm = 1'b0;
   logic         recv_calm = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   ibm_track_layout_formatter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   function automatic void note_error(string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   function automatic void add_run(logic [7:0] value, int count, logic last);
      int p;
      new_runs.push_back('{value, 16'(count), last});
      p = int'(trk_pos) + count;
      trk_pos = (p > 16'hFFFF) ? 16'hFFFF : 16'(p);
   endfunction

   // runs caused by one item, left in new_runs
   function automatic void lay_out_runs(req_data_type item);
      int nsec;
      int gap3;
      int tlen;
      new_runs = {};
      if (item.req_type == REQ_START) begin
         cur_cyl = item.cylinder;
         cur_head = item.head;
         trk_pos = '0;
         sec_idx = 0;
         byte_idx = 0;
         track_open = 1'b1;
         add_run(GAP_BYTE, 80, 1'b0);
         add_run(SYNC_BYTE, 12, 1'b0);
         add_run(IAM_BYTE, 3, 1'b0);
         add_run(IAM_MARK, 1, 1'b0);
         add_run(GAP_BYTE, 50, 1'b0);
      end else if (track_open) begin
         if (byte_idx == 0) begin
            add_run(SYNC_BYTE, 12, 1'b0);
            add_run(ADDR_BYTE, 3, 1'b0);
            add_run(IDAM_MARK, 1, 1'b0);
            add_run(cur_cyl, 1, 1'b0);
            add_run({7'd0, cur_head}, 1, 1'b0);
            add_run(8'(sec_idx + 1), 1, 1'b0);
            add_run(SIZE_CODE, 1, 1'b0);
            add_run(SYNC_BYTE, 2, 1'b0);
            add_run(GAP_BYTE, 22, 1'b0);
            add_run(SYNC_BYTE, 12, 1'b0);
            add_run(ADDR_BYTE, 3, 1'b0);
            add_run(DAM_MARK, 1, 1'b0);
         end
         add_run(item.data_absent ? FILL_BYTE : item.data_value, 1, 1'b0);
         byte_idx++;
         if (byte_idx >= SECTOR_BYTES) begin
            byte_idx = 0;
            nsec = (sectors_cfg == 0) ? 1 : int'(sectors_cfg);
            if (nsec > MAX_SECTORS) nsec = MAX_SECTORS;
            gap3 = (nsec <= 9) ? int'(GAP3_SHORT) :
                   (nsec <= 15) ? int'(GAP3_MEDIUM) : int'(GAP3_LONG);
            add_run(SYNC_BYTE, 2, 1'b0);
            add_run(GAP_BYTE, gap3, 1'b0);
            sec_idx++;
            if (sec_idx >= nsec) begin
               tlen = int'(trk_bytes_cfg);
               if (tlen < MIN_TRACK_BYTES) tlen = MIN_TRACK_BYTES;
               if (tlen > MAX_TRACK_BYTES) tlen = MAX_TRACK_BYTES;
               add_run(GAP_BYTE, (int'(trk_pos) < tlen) ? tlen - int'(trk_pos) : 0, 1'b1);
               track_open = 1'b0;
               sec_idx = 0;
            end
         end
      end
   endfunction

   function automatic req_data_type rand_item(logic kind);
      req_data_type r;
      r.req_type = kind;
      r.cylinder = 8'($urandom);
      r.head = 1'($urandom);
      r.data_value = 8'($urandom);
      r.data_absent = ($urandom_range(0, 7) == 0);
      return r;
   endfunction

   task automatic transfer(input req_data_type item);
      int gap;
      if ($urandom_range(0, 40) == 0) send_calm = ~send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_predicted(input req_data_type item);
      transfer(item);
      lay_out_runs(item);
      foreach (new_runs[i]) expected_runs.push_back(new_runs[i]);
   endtask

   task automatic send_bytes(input int n);
      repeat (n) send_predicted(rand_item(REQ_DATA));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // write, then read back
   task automatic write_reg(input logic which, input logic [15:0] value);
      logic [31:0] want;
      want = (which == REG_SECTORS) ? {26'd0, value[5:0]} : {16'd0, value};
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= {16'd0, value};
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want)
         note_error($sformatf("register %0d read: expected %h, got %h", which, want, csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (which == REG_SECTORS) sectors_cfg = value[5:0];
      else trk_bytes_cfg = value;
   endtask

   initial begin : stimulus
      int k;
      stim_row_type row;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIR_ROWS; k++) begin
         row = DIR_TABLE[k];
         transfer(row.rq);
         lay_out_runs(row.rq);
         case (row.form)
            ROW_PREDICT: begin
               foreach (new_runs[i]) expected_runs.push_back(new_runs[i]);
            end
            ROW_ONE_BYTE: begin
               expected_runs.push_back('{row.byte_exp, 16'd1, 1'b0});
            end
            ROW_PREAMBLE: begin
               foreach (PREAMBLE_RUNS[i]) expected_runs.push_back(PREAMBLE_RUNS[i]);
            end
            default: begin
            end
         endcase
      end

      // noise: mostly data, a start now and then
      repeat (110) send_predicted(rand_item(($urandom_range(0, 15) == 0) ? REQ_START : REQ_DATA));

      // zero sectors and zero length act as the minimums
      settle();
      write_reg(REG_SECTORS, 16'd0);
      write_reg(REG_TRACK_BYTES, 16'd0);
      send_predicted(rand_item(REQ_START));
      send_bytes(10);

      // oversized sector count and length clamp to the maximums
      settle();
      write_reg(REG_SECTORS, 16'd63);
      write_reg(REG_TRACK_BYTES, 16'hFFFF);
      send_predicted(rand_item(REQ_START));
      send_bytes(10);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : receiver
      int hold;
      rsp_data_type want;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 40) == 0) recv_calm = ~recv_calm;
         if (runs_seen == PRESSURE_AT) hold = HOLD_CYCLES;
         else hold = recv_calm ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         runs_seen++;
         if (expected_runs.size() == 0) begin
            note_error($sformatf("unexpected run: value %h count %0d last %b",
                                 rsp_data.run_value, rsp_data.run_count, rsp_data.last));
         end else begin
            want = expected_runs.pop_front();
            if (rsp_data.run_value !== want.run_value || rsp_data.run_count !== want.run_count ||
                rsp_data.last !== want.last)
               note_error($sformatf(
                  "run %0d: expected value %h count %0d last %b, got value %h count %0d last %b",
                  runs_seen, want.run_value, want.run_count, want.last,
                  rsp_data.run_value, rsp_data.run_count, rsp_data.last));
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
rtl/tlf_pkg.sv
rtl/tlf_csr.sv
rtl/tlf_seq.sv
rtl/tlf_out_reg.sv
rtl/ibm_track_layout_formatter.sv
tb/tb_top.sv
